FILE: rtl/core/h2r_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, conversion constants and shared types for the converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int HUE_W  = 9;
    localparam int CHAN_W = 8;
    localparam int REM_W  = 6;
    localparam int NUM_W  = 14;
    localparam int PROD_W = CHAN_W + NUM_W;
    localparam int RCP_W  = 23;
    localparam int RCP_SH = 36;

    localparam logic [HUE_W-1:0]  DEG_FULL   = 9'd360;
    localparam logic [REM_W-1:0]  DEG_SECTOR = 6'd60;
    localparam logic [CHAN_W-1:0] SAT_MAX    = 8'd255;
    localparam logic [NUM_W-1:0]  QT_DEN     = 14'd15300;

    // Rounded-up reciprocal of 15300 scaled by 2^36; exact for every numerator here.
    localparam logic [RCP_W-1:0]  QT_RECIP   = 23'd4491470;

    typedef enum logic [2:0] {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } h2r_sector_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } h2r_stage_en_t;

endpackage

FILE: rtl/core/h2r_sector.sv
// ----------------------------------------------------------------------------
// HSV to RGB sector stage
// Reduces the hue modulo 360 and splits it into a sector and a remainder.
// ----------------------------------------------------------------------------
module h2r_sector import h2r_pkg::*; (
    input  logic              aclk,
    input  h2r_stage_en_t     en,
    input  logic [HUE_W-1:0]  hue,
    input  logic [CHAN_W-1:0] saturation,
    input  logic [CHAN_W-1:0] brightness,
    output h2r_sector_t       sector,
    output logic [REM_W-1:0]  remainder,
    output logic [CHAN_W-1:0] sat_out,
    output logic [CHAN_W-1:0] val_out
);

    logic [HUE_W-1:0]  hue_mod;
    logic [HUE_W-1:0]  base;
    logic [HUE_W-1:0]  diff;
    h2r_sector_t       sector_next;
    logic [REM_W-1:0]  rem_next;
    h2r_sector_t       sector_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CHAN_W-1:0] sat_reg;
    logic [CHAN_W-1:0] val_reg;

    always_comb begin
        hue_mod = (hue >= DEG_FULL) ? hue - DEG_FULL : hue;
        priority if (hue_mod >= 9'd300) begin
            sector_next = SECT_5;
            base        = 9'd300;
        end else if (hue_mod >= 9'd240) begin
            sector_next = SECT_4;
            base        = 9'd240;
        end else if (hue_mod >= 9'd180) begin
            sector_next = SECT_3;
            base        = 9'd180;
        end else if (hue_mod >= 9'd120) begin
            sector_next = SECT_2;
            base        = 9'd120;
        end else if (hue_mod >= {3'd0, DEG_SECTOR}) begin
            sector_next = SECT_1;
            base        = {3'd0, DEG_SECTOR};
        end else begin
            sector_next = SECT_0;
            base        = '0;
        end
        diff     = hue_mod - base;
        rem_next = diff[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            sector_reg <= sector_next;
            rem_reg    <= rem_next;
            sat_reg    <= saturation;
            val_reg    <= brightness;
        end
    end

    assign sector    = sector_reg;
    assign remainder = rem_reg;
    assign sat_out   = sat_reg;
    assign val_out   = val_reg;

endmodule

FILE: rtl/core/h2r_terms.sv
// ----------------------------------------------------------------------------
// HSV to RGB term stages
// Forms the numerators, scales them by the value and divides by the constants
// over three register stages to give the p, q and t terms.
// ----------------------------------------------------------------------------
module h2r_terms import h2r_pkg::*; (
    input  logic              aclk,
    input  h2r_stage_en_t     en,
    input  h2r_sector_t       sector,
    input  logic [REM_W-1:0]  remainder,
    input  logic [CHAN_W-1:0] saturation,
    input  logic [CHAN_W-1:0] brightness,
    output h2r_sector_t       sector_out,
    output logic [CHAN_W-1:0] val_out,
    output logic [CHAN_W-1:0] p_term,
    output logic [CHAN_W-1:0] q_term,
    output logic [CHAN_W-1:0] t_term
);

    localparam int WIDE_W = PROD_W + RCP_W;

    logic [NUM_W-1:0]   rs_prod;
    logic [NUM_W-1:0]   ts_prod;
    logic [REM_W-1:0]   rem_inv;
    logic [CHAN_W-1:0]  pn_next;
    logic [NUM_W-1:0]   qn_next;
    logic [NUM_W-1:0]   tn_next;
    h2r_sector_t        sect2_reg;
    logic [CHAN_W-1:0]  val2_reg;
    logic [CHAN_W-1:0]  pn_reg;
    logic [NUM_W-1:0]   qn_reg;
    logic [NUM_W-1:0]   tn_reg;

    logic [2*CHAN_W-1:0] vp_next;
    logic [PROD_W-1:0]   vq_next;
    logic [PROD_W-1:0]   vt_next;
    h2r_sector_t         sect3_reg;
    logic [CHAN_W-1:0]   val3_reg;
    logic [2*CHAN_W-1:0] vp_reg;
    logic [PROD_W-1:0]   vq_reg;
    logic [PROD_W-1:0]   vt_reg;

    logic [2*CHAN_W:0]   vp_sum;
    logic [WIDE_W-1:0]   q_wide;
    logic [WIDE_W-1:0]   t_wide;
    h2r_sector_t         sect4_reg;
    logic [CHAN_W-1:0]   val4_reg;
    logic [CHAN_W-1:0]   p_reg;
    logic [CHAN_W-1:0]   q_reg;
    logic [CHAN_W-1:0]   t_reg;

    always_comb begin
        rem_inv = DEG_SECTOR - remainder;
        rs_prod = NUM_W'({8'd0, remainder} * {6'd0, saturation});
        ts_prod = NUM_W'({8'd0, rem_inv} * {6'd0, saturation});
        pn_next = SAT_MAX - saturation;
        qn_next = QT_DEN - rs_prod;
        tn_next = QT_DEN - ts_prod;
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            sect2_reg <= sector;
            val2_reg  <= brightness;
            pn_reg    <= pn_next;
            qn_reg    <= qn_next;
            tn_reg    <= tn_next;
        end
    end

    always_comb begin
        vp_next = {8'd0, val2_reg} * {8'd0, pn_reg};
        vq_next = {14'd0, val2_reg} * {8'd0, qn_reg};
        vt_next = {14'd0, val2_reg} * {8'd0, tn_reg};
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            sect3_reg <= sect2_reg;
            val3_reg  <= val2_reg;
            vp_reg    <= vp_next;
            vq_reg    <= vq_next;
            vt_reg    <= vt_next;
        end
    end

    // Division by 255 is exact for any product of two 8-bit values in this add-and-shift form.
    always_comb begin
        vp_sum = {1'b0, vp_reg} + {9'd0, vp_reg[2*CHAN_W-1:CHAN_W]} + 17'd1;
        q_wide = {{RCP_W{1'b0}}, vq_reg} * {{PROD_W{1'b0}}, QT_RECIP};
        t_wide = {{RCP_W{1'b0}}, vt_reg} * {{PROD_W{1'b0}}, QT_RECIP};
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            sect4_reg <= sect3_reg;
            val4_reg  <= val3_reg;
            p_reg     <= vp_sum[2*CHAN_W-1:CHAN_W];
            q_reg     <= q_wide[RCP_SH+CHAN_W-1:RCP_SH];
            t_reg     <= t_wide[RCP_SH+CHAN_W-1:RCP_SH];
        end
    end

    assign sector_out = sect4_reg;
    assign val_out    = val4_reg;
    assign p_term     = p_reg;
    assign q_term     = q_reg;
    assign t_term     = t_reg;

endmodule

FILE: rtl/core/h2r_mixer.sv
// ----------------------------------------------------------------------------
// HSV to RGB channel mixer
// Chooses the channel order for the sector and holds the output register.
// ----------------------------------------------------------------------------
module h2r_mixer import h2r_pkg::*; (
    input  logic              aclk,
    input  h2r_stage_en_t     en,
    input  h2r_sector_t       sector,
    input  logic [CHAN_W-1:0] brightness,
    input  logic [CHAN_W-1:0] p_term,
    input  logic [CHAN_W-1:0] q_term,
    input  logic [CHAN_W-1:0] t_term,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue
);

    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;

    always_comb begin
        unique case (sector)
            SECT_0: begin
                red_next = brightness; green_next = t_term;     blue_next = p_term;
            end
            SECT_1: begin
                red_next = q_term;     green_next = brightness; blue_next = p_term;
            end
            SECT_2: begin
                red_next = p_term;     green_next = brightness; blue_next = t_term;
            end
            SECT_3: begin
                red_next = p_term;     green_next = q_term;     blue_next = brightness;
            end
            SECT_4: begin
                red_next = t_term;     green_next = p_term;     blue_next = brightness;
            end
            default: begin
                red_next = brightness; green_next = p_term;     blue_next = q_term;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: rtl/core/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a stream of HSV pixels (9-bit hue, 8-bit saturation and value) into 8-bit RGB pixels.
// ----------------------------------------------------------------------------
// The slave channel takes one pixel per request: hue in degrees (values from
// 360 upwards wrap round), saturation and value. The master channel returns
// one request per pixel holding red, green and blue, in the order received.
// The converter is a five-stage pipeline: sector split, numerator products,
// scaling by the value, division by the constants and channel selection.
// The result passes the sector, numerator, scaling, division and channel
// registers in turn before it appears on the master side, and one pixel is
// accepted in every cycle while the receiver keeps up. The scaling and
// division multipliers set the stage depth.
// When the receiver stalls, each stage holds its pixel and empty stages
// further up keep filling, so bubbles are squeezed out before s_tready
// drops; nothing is lost or repeated. Reset empties the pipeline and holds
// s_tready low; requests are taken from the first cycle after aresetn rises.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import h2r_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // hue[8:0], saturation[16:9], brightness[24:17], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // red[7:0], green[15:8], blue[23:16]
);

    logic [4:0]        vld_reg;
    logic [4:0]        vld_next;
    h2r_stage_en_t     en;

    h2r_sector_t       sect_a;
    logic [REM_W-1:0]  rem_a;
    logic [CHAN_W-1:0] sat_a;
    logic [CHAN_W-1:0] val_a;
    h2r_sector_t       sect_b;
    logic [CHAN_W-1:0] val_b;
    logic [CHAN_W-1:0] p_b;
    logic [CHAN_W-1:0] q_b;
    logic [CHAN_W-1:0] t_b;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    always_comb begin
        en.s5 = !vld_reg[4] || m_tready;
        en.s4 = !vld_reg[3] || en.s5;
        en.s3 = !vld_reg[2] || en.s4;
        en.s2 = !vld_reg[1] || en.s3;
        en.s1 = !vld_reg[0] || en.s2;
        vld_next[0] = en.s1 ? s_tvalid   : vld_reg[0];
        vld_next[1] = en.s2 ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en.s3 ? vld_reg[1] : vld_reg[2];
        vld_next[3] = en.s4 ? vld_reg[2] : vld_reg[3];
        vld_next[4] = en.s5 ? vld_reg[3] : vld_reg[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    h2r_sector u_sector (
        .aclk       (aclk),
        .en         (en),
        .hue        (s_tdata[8:0]),
        .saturation (s_tdata[16:9]),
        .brightness (s_tdata[24:17]),
        .sector     (sect_a),
        .remainder  (rem_a),
        .sat_out    (sat_a),
        .val_out    (val_a)
    );

    h2r_terms u_terms (
        .aclk       (aclk),
        .en         (en),
        .sector     (sect_a),
        .remainder  (rem_a),
        .saturation (sat_a),
        .brightness (val_a),
        .sector_out (sect_b),
        .val_out    (val_b),
        .p_term     (p_b),
        .q_term     (q_b),
        .t_term     (t_b)
    );

    h2r_mixer u_mixer (
        .aclk       (aclk),
        .en         (en),
        .sector     (sect_b),
        .brightness (val_b),
        .p_term     (p_b),
        .q_term     (q_b),
        .t_term     (t_b),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign s_tready = en.s1 && aresetn;
    assign m_tvalid = vld_reg[4];
    assign m_tdata  = {blue, green, red};

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("Accepted pixel did not enter the first stage.");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_tready)
        else $error("Converter refused a pixel with its first stage empty.");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg) && !m_tready |-> !s_tready)
        else $error("Converter accepted a pixel while full and stalled.");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !vld_reg[3] |=> !m_tvalid)
        else $error("Result repeated after it was taken.");

endmodule
